/* src/assert_macros.svh */
// Assertion macros used by the top-level RTL file of the FNV-1a fingerprint block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every clock edge outside reset.
`define FNVLF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define FNVLF_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a condition implies a consequence in the next cycle.
`define FNVLF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/fnvlf_pkg.sv */
// Package with constants, types and the hash step of the FNV-1a fingerprint block.
package fnvlf_pkg;

    localparam int BYTE_COUNT_BITS   = 32;
    localparam int RECORD_COUNT_BITS = 32;
    localparam int BYTE_CMP_BITS     = (BYTE_COUNT_BITS > 32) ? BYTE_COUNT_BITS : 32;
    localparam int REC_CMP_BITS      = (RECORD_COUNT_BITS > 32) ? RECORD_COUNT_BITS : 32;

    localparam logic [63:0] FNV_OFFSET_BASIS = 64'd14695981039346656037;
    localparam logic [7:0]  NEWLINE_BYTE     = 8'h0A;

    localparam logic REQ_DATA = 1'b0;
    localparam logic REQ_END  = 1'b1;

    localparam int CFG_ADDR_BITS = 3;
    localparam logic CFG_BYTE_LIMIT   = 1'b0;
    localparam logic CFG_RECORD_LIMIT = 1'b1;

    localparam logic [31:0] BYTE_LIMIT_RESET   = 32'd1048576;
    localparam logic [31:0] RECORD_LIMIT_RESET = 32'd65536;

    typedef struct packed {
        logic        status;
        logic [63:0] digest;
        logic [31:0] total_bytes;
        logic [31:0] total_records;
        logic        ends_with_newline;
    } t_result;

    typedef struct packed {
        logic stream_empty;
        logic limit_error;
    } t_core_status;

    // Multiplies by the FNV prime 2^40 + 435 modulo 2^64 as a shift-add.
    function automatic logic [63:0] fnv_prime_mul(input logic [63:0] h);
        fnv_prime_mul = h + (h << 1) + (h << 4) + (h << 5) + (h << 7) + (h << 8)
                      + (h << 40);
    endfunction

endpackage

/* src/fnvlf_req_if.sv */
// Interface for the request channel carrying data and end-of-stream beats.
interface fnvlf_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] data_byte;

    modport source (output valid, output req_type, output data_byte, input ready);
    modport sink (input valid, input req_type, input data_byte, output ready);
endinterface

/* src/fnvlf_res_if.sv */
// Interface for the result channel carrying one fingerprint beat per stream.
interface fnvlf_res_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic [63:0] digest;
    logic [31:0] total_bytes;
    logic [31:0] total_records;
    logic        ends_with_newline;

    modport source (output valid, output status, output digest, output total_bytes,
                    output total_records, output ends_with_newline, input ready);
    modport sink (input valid, input status, input digest, input total_bytes,
                  input total_records, input ends_with_newline, output ready);
endinterface

/* src/fnvlf_cfg_regs.sv */
// APB register file holding the byte and record limits.
module fnvlf_cfg_regs
    import fnvlf_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    output logic [31:0]              o_byte_limit,
    output logic [31:0]              o_record_limit
);

    logic [31:0] r_byte_limit;
    logic [31:0] r_record_limit;
    logic        w_index;
    logic        w_write;

    assign pready  = 1'b1;
    assign w_index = paddr[2];
    assign w_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_limit   <= BYTE_LIMIT_RESET;
            r_record_limit <= RECORD_LIMIT_RESET;
        end else if (w_write) begin
            unique case (w_index)
                CFG_BYTE_LIMIT:   r_byte_limit   <= pwdata;
                CFG_RECORD_LIMIT: r_record_limit <= pwdata;
                default:          r_byte_limit   <= r_byte_limit;
            endcase
        end
    end

    always_comb begin
        unique case (w_index)
            CFG_BYTE_LIMIT:   prdata = r_byte_limit;
            CFG_RECORD_LIMIT: prdata = r_record_limit;
            default:          prdata = '0;
        endcase
    end

    assign o_byte_limit   = r_byte_limit;
    assign o_record_limit = r_record_limit;

endmodule

/* src/fnvlf_hash_core.sv */
// Stream state: running hash, byte and record counters, limit checks and result.
module fnvlf_hash_core
    import fnvlf_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_step,
    input  logic         i_req_type,
    input  logic [7:0]   i_data_byte,
    input  logic [31:0]  i_byte_limit,
    input  logic [31:0]  i_record_limit,
    output logic         o_res_valid,
    output t_result      o_res,
    output t_core_status o_status
);

    logic [63:0]                  r_hash;
    logic [BYTE_COUNT_BITS-1:0]   r_byte_cnt;
    logic [RECORD_COUNT_BITS-1:0] r_nl_cnt;
    logic                         r_last_nl;
    logic                         r_err;

    logic [63:0]                  n_hash;
    logic [BYTE_COUNT_BITS-1:0]   n_byte_cnt;
    logic [RECORD_COUNT_BITS-1:0] n_nl_cnt;
    logic                         n_last_nl;
    logic                         n_err;

    logic                         w_byte_full;
    logic                         w_rec_full;
    logic                         w_is_nl;
    logic                         w_add_tail;
    logic                         w_end_err;
    logic [RECORD_COUNT_BITS-1:0] w_rec_total;

    assign w_byte_full = (BYTE_CMP_BITS'(r_byte_cnt) >= BYTE_CMP_BITS'(i_byte_limit))
                      || (r_byte_cnt == '1);
    assign w_rec_full  = (REC_CMP_BITS'(r_nl_cnt) >= REC_CMP_BITS'(i_record_limit))
                      || (r_nl_cnt == '1);
    assign w_is_nl     = (i_data_byte == NEWLINE_BYTE);
    assign w_add_tail  = !r_err && (r_byte_cnt != '0) && !r_last_nl;
    assign w_end_err   = r_err || (w_add_tail && w_rec_full);
    assign w_rec_total = w_add_tail ? r_nl_cnt + 1'b1 : r_nl_cnt;

    always_comb begin
        n_hash     = r_hash;
        n_byte_cnt = r_byte_cnt;
        n_nl_cnt   = r_nl_cnt;
        n_last_nl  = r_last_nl;
        n_err      = r_err;
        if (i_step) begin
            if (i_req_type == REQ_END) begin
                n_hash     = FNV_OFFSET_BASIS;
                n_byte_cnt = '0;
                n_nl_cnt   = '0;
                n_last_nl  = 1'b0;
                n_err      = 1'b0;
            end else if (!r_err) begin
                if (w_byte_full) begin
                    n_err = 1'b1;
                end else begin
                    n_hash     = fnv_prime_mul(r_hash ^ {56'd0, i_data_byte});
                    n_byte_cnt = r_byte_cnt + 1'b1;
                    n_last_nl  = w_is_nl;
                    if (w_is_nl) begin
                        if (w_rec_full) begin
                            n_err = 1'b1;
                        end else begin
                            n_nl_cnt = r_nl_cnt + 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash     <= FNV_OFFSET_BASIS;
            r_byte_cnt <= '0;
            r_nl_cnt   <= '0;
            r_last_nl  <= 1'b0;
            r_err      <= 1'b0;
        end else begin
            r_hash     <= n_hash;
            r_byte_cnt <= n_byte_cnt;
            r_nl_cnt   <= n_nl_cnt;
            r_last_nl  <= n_last_nl;
            r_err      <= n_err;
        end
    end

    assign o_res_valid = i_step && (i_req_type == REQ_END);

    always_comb begin
        o_res = '0;
        if (w_end_err) begin
            o_res.status = 1'b1;
        end else begin
            o_res.status            = 1'b0;
            o_res.digest            = r_hash;
            o_res.total_bytes       = 32'(r_byte_cnt);
            o_res.total_records     = 32'(w_rec_total);
            o_res.ends_with_newline = r_last_nl;
        end
    end

    assign o_status.stream_empty = (r_byte_cnt == '0) && !r_err && (r_hash == FNV_OFFSET_BASIS);
    assign o_status.limit_error  = r_err;

endmodule

/* src/fnv1a64_line_fingerprint.sv */
// Top level of the FNV-1a 64-bit line fingerprint block.
// The block takes one request beat per clock, a data byte or an end-of-stream mark, unless
// an end mark is held back by a full output register, and returns one result beat per end
// mark carrying the 64-bit FNV-1a digest, the byte count, the record count and the
// final-newline flag, or an error status with all other fields zero when the byte or
// record limit was passed. Every beat passes an input register and then updates the
// stream state; an end mark writes its result into the output register when it steps the
// stream state. The clock rate is set by the hash loop: one XOR and a seven-term 64-bit
// shift-add for the prime multiply on the path from the running hash register back to
// itself. Data beats keep flowing while a result waits on the output; only a second end
// mark waits for the output register to be taken. Limits are written over APB at byte
// addresses 0 and 4 and should only change while no stream is in flight.
`include "assert_macros.svh"

module fnv1a64_line_fingerprint
    import fnvlf_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    fnvlf_req_if.sink                i_req,
    fnvlf_res_if.source              o_res,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    logic         r_in_vld;
    logic         r_in_req;
    logic [7:0]   r_in_byte;
    logic         r_out_vld;
    t_result      r_out;

    logic         w_step;
    logic         w_res_vld;
    t_result      w_res;
    t_core_status w_status;
    logic [31:0]  w_byte_limit;
    logic [31:0]  w_record_limit;

    fnvlf_cfg_regs u_cfg_regs (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_byte_limit   (w_byte_limit),
        .o_record_limit (w_record_limit)
    );

    fnvlf_hash_core u_hash_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (w_step),
        .i_req_type     (r_in_req),
        .i_data_byte    (r_in_byte),
        .i_byte_limit   (w_byte_limit),
        .i_record_limit (w_record_limit),
        .o_res_valid    (w_res_vld),
        .o_res          (w_res),
        .o_status       (w_status)
    );

    assign w_step      = r_in_vld && ((r_in_req == REQ_DATA) || !r_out_vld || o_res.ready);
    assign i_req.ready = !r_in_vld || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_req.ready) begin
            r_in_vld <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_in_req  <= i_req.req_type;
            r_in_byte <= i_req.data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_res_vld) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_vld) begin
            r_out <= w_res;
        end
    end

    assign o_res.valid             = r_out_vld;
    assign o_res.status            = r_out.status;
    assign o_res.digest            = r_out.digest;
    assign o_res.total_bytes       = r_out.total_bytes;
    assign o_res.total_records     = r_out.total_records;
    assign o_res.ends_with_newline = r_out.ends_with_newline;

    `FNVLF_ASSERT_IMPL(a_err_zero_fields, r_out_vld && r_out.status, (r_out.digest == '0) && (r_out.total_bytes == '0) && (r_out.total_records == '0) && !r_out.ends_with_newline, "Error result carries nonzero fields.")
    `FNVLF_ASSERT_NEXT(a_end_gives_result, w_step && (r_in_req == REQ_END), r_out_vld && w_status.stream_empty, "End beat did not produce a result and clear the stream.")
    `FNVLF_ASSERT_IMPL(a_no_overwrite, w_res_vld, !r_out_vld || o_res.ready, "Result register overwritten before it was taken.")
    `FNVLF_ASSERT_IMPL(a_empty_input_ready, !r_in_vld, i_req.ready, "Input stalled while the input register is empty.")

endmodule
